// File: design/swtl_pkg.sv
// Shared types and constants of the sorted word table lookup engine.
// Used by swtl_store and sorted_word_table_lookup; no dependencies.

package swtl_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned MAX_LEN     = 64;

  localparam int unsigned POS_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned ENT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LEN_W      = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W     = ENT_W + POS_W;
  localparam int unsigned BYTE_DEPTH = 1 << ADDR_W;
  localparam int unsigned LEN_DEPTH  = 1 << ENT_W;
  localparam int unsigned QBUF_DEPTH = 1 << POS_W;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_LONG    = 3'd2,
    ST_ANSWER  = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MID,
    S_FETCH,
    S_CMP
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic              byte_we;
    logic [ADDR_W-1:0] byte_addr;
    logic [7:0]        byte_data;
    logic              len_we;
    logic [ENT_W-1:0]  len_addr;
    logic [LEN_W-1:0]  len_data;
  } tbl_wr_t;

endpackage

// File: design/sorted_word_table_lookup.sv
// Top level of the sorted word table lookup engine: sequencer, query buffer,
// byte-serial comparator and binary search. Depends on swtl_pkg, swtl_store.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (req_type, char_code, last_char)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (found, status)
//
// Characters, loads and clears are handled directly in the idle state. A query's last character
// starts a binary search: each probe compares up to min(entry length, query length)
// bytes in the shared byte comparator, over up to log2(entry count) + 1 probes.
// Reset clears the entry count and the collected word; table contents need none.
// Input stalls while a search runs or while an untaken result blocks the output.

module sorted_word_table_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swtl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swtl_pkg::out_item_t out_data_o
);
  import swtl_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic             over_q, over_d;
  logic [LEN_W-1:0] qlen_q, qlen_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hix_q, hix_d;
  logic [ENT_W-1:0] mid_q, mid_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] cmp_idx_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [7:0]       qbuf_mem [QBUF_DEPTH];
  logic [7:0]       qbuf_rd_q;

  tbl_wr_t          tbl_wr;
  logic [7:0]       tbl_byte;
  logic [LEN_W-1:0] tbl_len;

  req_e             req;
  logic             accept;
  logic             is_char;
  logic             fits;
  logic             full;
  logic             too_long;
  logic [LEN_W-1:0] word_len;
  logic             start_search;
  logic             probe_live;
  logic [CNT_W:0]   mid_sum;
  logic [LEN_W-1:0] cmp_n;
  logic             at_end;
  logic             decided;
  logic             match;
  logic             entry_gt;

  assign req          = req_e'(in_data_i.req_type);
  assign in_ready_o   = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign is_char      = (req == REQ_LOAD) || (req == REQ_QUERY);
  assign fits         = pos_q < LEN_W'(MAX_LEN);
  assign full         = count_q == CNT_W'(TABLE_DEPTH);
  assign too_long     = over_q || !fits;
  assign word_len     = fits ? pos_q + LEN_W'(1) : pos_q;
  assign start_search = accept && is_char && in_data_i.last_char && (req == REQ_QUERY)
                        && !too_long && (count_q != '0);

  assign probe_live = lo_q < hix_q;
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hix_q} - (CNT_W + 1)'(1);

  assign cmp_n    = (tbl_len < qlen_q) ? tbl_len : qlen_q;
  assign at_end   = cmp_idx_q == cmp_n;
  assign decided  = at_end || (tbl_byte != qbuf_rd_q);
  assign match    = at_end && (tbl_len == qlen_q);
  assign entry_gt = at_end ? (tbl_len > qlen_q) : (tbl_byte > qbuf_rd_q);

  always_comb begin
    tbl_wr           = '0;
    tbl_wr.byte_we   = accept && is_char && fits && !full;
    tbl_wr.byte_addr = {count_q[ENT_W-1:0], pos_q[POS_W-1:0]};
    tbl_wr.byte_data = in_data_i.char_code;
    tbl_wr.len_we    = accept && (req == REQ_LOAD) && in_data_i.last_char
                       && !full && !too_long;
    tbl_wr.len_addr  = count_q[ENT_W-1:0];
    tbl_wr.len_data  = word_len;
  end

  swtl_store u_store (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_entry_i (mid_q),
    .rd_pos_i   (idx_q[POS_W-1:0]),
    .rd_byte_o  (tbl_byte),
    .rd_len_o   (tbl_len)
  );

  always_ff @(posedge clk_i) begin
    if (accept && is_char && fits) begin
      qbuf_mem[pos_q[POS_W-1:0]] <= in_data_i.char_code;
    end
    qbuf_rd_q <= qbuf_mem[idx_q[POS_W-1:0]];
    cmp_idx_q <= idx_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_search) begin
          state_d = S_MID;
        end
      end
      S_MID: begin
        state_d = probe_live ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        priority if (match) begin
          state_d = S_IDLE;
        end else if (decided) begin
          state_d = S_MID;
        end else begin
          state_d = S_CMP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    over_d      = over_q;
    qlen_d      = qlen_q;
    lo_d        = lo_q;
    hix_d       = hix_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req == REQ_CLEAR)) begin
          count_d     = '0;
          pos_d       = '0;
          over_d      = 1'b0;
          out_valid_d = 1'b1;
          out_d       = '{found: 1'b0, status: ST_CLEARED};
        end else if (accept && is_char) begin
          if (fits) begin
            pos_d = pos_q + LEN_W'(1);
          end else begin
            over_d = 1'b1;
          end
          if (in_data_i.last_char) begin
            pos_d  = '0;
            over_d = 1'b0;
            if (req == REQ_QUERY) begin
              qlen_d = word_len;
              lo_d   = '0;
              hix_d  = count_q;
              if (!start_search) begin
                out_valid_d = 1'b1;
                out_d       = '{found: 1'b0, status: ST_ANSWER};
              end
            end else begin
              out_valid_d = 1'b1;
              priority if (full) begin
                out_d = '{found: 1'b0, status: ST_FULL};
              end else if (too_long) begin
                out_d = '{found: 1'b0, status: ST_LONG};
              end else begin
                count_d = count_q + CNT_W'(1);
                out_d   = '{found: 1'b0, status: ST_STORED};
              end
            end
          end
        end
      end
      S_MID: begin
        mid_d = mid_sum[ENT_W:1];
        idx_d = '0;
        if (!probe_live) begin
          out_valid_d = 1'b1;
          out_d       = '{found: 1'b0, status: ST_ANSWER};
        end
      end
      S_FETCH: begin
        idx_d = idx_q + LEN_W'(1);
      end
      S_CMP: begin
        priority if (match) begin
          out_valid_d = 1'b1;
          out_d       = '{found: 1'b1, status: ST_ANSWER};
        end else if (decided) begin
          if (entry_gt) begin
            hix_d = CNT_W'(mid_q);
          end else begin
            lo_d = CNT_W'(mid_q) + CNT_W'(1);
          end
        end else begin
          idx_d = idx_q + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qlen_q <= qlen_d;
    lo_q   <= lo_d;
    hix_q  <= hix_d;
    mid_q  <= mid_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input ready while search runs");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (CNT_W'(mid_q) < count_q))
    else $error("probe beyond stored entries");

  a_bound_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (hix_q <= count_q))
    else $error("search bound beyond entry count");

  a_search_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_search |=> (state_q == S_MID) && !out_valid_o)
    else $error("search start left a result pending");

endmodule

// File: design/swtl_store.sv
// Word table storage: character bytes per entry and entry lengths.
// Depends on swtl_pkg; one write and one registered read per memory.

module swtl_store (
  input  logic                        clk_i,
  input  swtl_pkg::tbl_wr_t           wr_i,
  input  logic [swtl_pkg::ENT_W-1:0]  rd_entry_i,
  input  logic [swtl_pkg::POS_W-1:0]  rd_pos_i,
  output logic [7:0]                  rd_byte_o,
  output logic [swtl_pkg::LEN_W-1:0]  rd_len_o
);
  import swtl_pkg::*;

  logic [7:0]       byte_mem [BYTE_DEPTH];
  logic [LEN_W-1:0] len_mem  [LEN_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.byte_we) begin
      byte_mem[wr_i.byte_addr] <= wr_i.byte_data;
    end
    rd_byte_o <= byte_mem[{rd_entry_i, rd_pos_i}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.len_we) begin
      len_mem[wr_i.len_addr] <= wr_i.len_data;
    end
    rd_len_o <= len_mem[rd_entry_i];
  end

endmodule
